/* design/amgd_pkg.sv */
package amgd_pkg;

    localparam int MAX_VERTEX_COUNT = 64;
    // Vertex numbers are six bits wide, so no more than 64 vertices can exist.
    localparam int VERTEX_LIMIT     = (MAX_VERTEX_COUNT > 64) ? 64 : MAX_VERTEX_COUNT;
    localparam int VERTEX_NUM       = 64;
    localparam int VID_W            = 6;
    localparam int CNT_W            = 7;
    localparam int DEG_STEPS        = VERTEX_NUM / 8;

    typedef enum logic [1:0] {
        ACT_ADD_VERTEX = 2'd0,
        ACT_ADD_EDGE   = 2'd1,
        ACT_DEGREE     = 2'd2,
        ACT_DFS        = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_LIMIT = 2'd1,
        ST_RANGE = 2'd2
    } t_status;

    typedef struct packed {
        t_action            action;
        logic [VID_W-1:0]   vertex_a;
        logic [VID_W-1:0]   vertex_b;
    } t_item;

    typedef struct packed {
        t_status            status;
        logic [VID_W-1:0]   vertex_id;
        logic [CNT_W-1:0]   degree;
        logic               last;
    } t_result;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EDGE_A,
        S_EDGE_B,
        S_DEG_LOAD,
        S_DEG_CNT,
        S_DFS_SCAN,
        S_DFS_POP
    } t_state;

    function automatic logic [3:0] pop8(input logic [7:0] x);
        logic [3:0] c;
        c = '0;
        for (int i = 0; i < 8; i++) begin
            c = c + {3'b000, x[i]};
        end
        return c;
    endfunction

endpackage

/* design/adjacency_matrix_graph_dfs.sv */
// Channel   Ports                          Direction  Transfer
// command   start, busy, i_item            in         start high and busy low at the edge
// result    o_strobe, o_result             out        o_strobe high for one cycle, always taken
//
// Add vertex and rejected commands answer in the cycle after the command, and busy stays low.
// Add edge updates row a, then row b; a degree query makes one pass of 8 bits per cycle
// through a popcount. A traversal scans each reached vertex and pops the stack to backtrack,
// bounded by the single read port of the adjacency memory and of the stack memory.
// Reset clears the count and the per-row valid bits at once; there is no clearing pass.
// Results cannot be stalled, so each one appears on the ports for exactly one cycle.
module adjacency_matrix_graph_dfs (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  amgd_pkg::t_item   i_item,
    output logic              o_strobe,
    output amgd_pkg::t_result o_result
);
    import amgd_pkg::*;

    t_state r_state, n_state;

    logic [CNT_W-1:0]      r_count, n_count;
    logic [VID_W-1:0]      r_va, n_va;
    logic [VID_W-1:0]      r_vb, n_vb;
    logic [VERTEX_NUM-1:0] r_visited, n_visited;
    logic [VID_W-1:0]      r_top, n_top;
    logic [CNT_W-1:0]      r_depth, n_depth;
    logic [VID_W-1:0]      r_pend, n_pend;
    logic [VERTEX_NUM-1:0] r_shift, n_shift;
    logic [CNT_W-1:0]      r_acc, n_acc;
    logic [2:0]            r_step, n_step;
    t_result               r_out, n_out;
    logic                  r_strobe, n_strobe;

    // Adjacency memory with one valid bit per row; a row never written reads as zero.
    logic [VERTEX_NUM-1:0] r_adj [VERTEX_NUM];
    logic [VERTEX_NUM-1:0] r_row_vld;
    logic [VERTEX_NUM-1:0] r_row_q;
    logic                  r_row_q_vld;
    logic                  adj_rd_en, adj_wr_en;
    logic [VID_W-1:0]      adj_rd_addr, adj_wr_addr;
    logic [VERTEX_NUM-1:0] adj_wr_data;
    logic [VERTEX_NUM-1:0] row;

    // Stack of ancestors below the current top vertex, which is held in r_top.
    logic [VID_W-1:0]      r_stk [VERTEX_NUM];
    logic [VID_W-1:0]      r_stk_q;
    logic                  stk_rd_en, stk_wr_en;
    logic [VID_W-1:0]      stk_rd_addr, stk_wr_addr;

    logic [VERTEX_NUM-1:0] cand, cand_low;
    logic [VID_W-1:0]      cand_idx;
    logic                  accept;
    logic                  a_bad, b_bad;
    logic [CNT_W-1:0]      depth_m1, depth_m2;

    assign row      = r_row_q_vld ? r_row_q : '0;
    assign cand     = row & ~r_visited;
    assign cand_low = cand & (~cand + 64'd1);

    always_comb begin
        cand_idx = '0;
        for (int k = 0; k < VID_W; k++) begin
            for (int i = 0; i < VERTEX_NUM; i++) begin
                if (((i >> k) & 1) == 1) begin
                    cand_idx[k] = cand_idx[k] | cand_low[i];
                end
            end
        end
    end

    assign accept   = start && (r_state == S_IDLE);
    assign a_bad    = {1'b0, i_item.vertex_a} >= r_count;
    assign b_bad    = {1'b0, i_item.vertex_b} >= r_count;
    assign depth_m1 = r_depth - 7'd1;
    assign depth_m2 = r_depth - 7'd2;

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_va        = r_va;
        n_vb        = r_vb;
        n_visited   = r_visited;
        n_top       = r_top;
        n_depth     = r_depth;
        n_pend      = r_pend;
        n_shift     = r_shift;
        n_acc       = r_acc;
        n_step      = r_step;
        n_out       = r_out;
        n_strobe    = 1'b0;
        adj_rd_en   = 1'b0;
        adj_rd_addr = r_va;
        adj_wr_en   = 1'b0;
        adj_wr_addr = r_va;
        adj_wr_data = row;
        stk_rd_en   = 1'b0;
        stk_rd_addr = depth_m2[VID_W-1:0];
        stk_wr_en   = 1'b0;
        stk_wr_addr = depth_m1[VID_W-1:0];

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_va          = i_item.vertex_a;
                    n_vb          = i_item.vertex_b;
                    n_out.status    = ST_OK;
                    n_out.vertex_id = '0;
                    n_out.degree    = '0;
                    n_out.last      = 1'b1;
                    case (i_item.action)
                        ACT_ADD_VERTEX: begin
                            n_strobe = 1'b1;
                            if (r_count >= CNT_W'(VERTEX_LIMIT)) begin
                                n_out.status = ST_LIMIT;
                            end else begin
                                n_out.vertex_id = r_count[VID_W-1:0];
                                n_count         = r_count + 7'd1;
                            end
                        end
                        ACT_ADD_EDGE: begin
                            if (a_bad || b_bad) begin
                                n_strobe     = 1'b1;
                                n_out.status = ST_RANGE;
                            end else begin
                                adj_rd_en   = 1'b1;
                                adj_rd_addr = i_item.vertex_a;
                                n_state     = S_EDGE_A;
                            end
                        end
                        ACT_DEGREE: begin
                            if (a_bad) begin
                                n_strobe     = 1'b1;
                                n_out.status = ST_RANGE;
                            end else begin
                                adj_rd_en   = 1'b1;
                                adj_rd_addr = i_item.vertex_a;
                                n_state     = S_DEG_LOAD;
                            end
                        end
                        ACT_DFS: begin
                            if (a_bad) begin
                                n_strobe     = 1'b1;
                                n_out.status = ST_RANGE;
                            end else begin
                                n_visited   = 64'd1 << i_item.vertex_a;
                                n_top       = i_item.vertex_a;
                                n_pend      = i_item.vertex_a;
                                n_depth     = 7'd1;
                                adj_rd_en   = 1'b1;
                                adj_rd_addr = i_item.vertex_a;
                                n_state     = S_DFS_SCAN;
                            end
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end

            S_EDGE_A: begin
                // The read of the second row sees the old contents, which is right
                // even for a self loop since both updates set the same bit.
                adj_wr_en   = 1'b1;
                adj_wr_addr = r_va;
                adj_wr_data = row | (64'd1 << r_vb);
                adj_rd_en   = 1'b1;
                adj_rd_addr = r_vb;
                n_state     = S_EDGE_B;
            end

            S_EDGE_B: begin
                adj_wr_en   = 1'b1;
                adj_wr_addr = r_vb;
                adj_wr_data = row | (64'd1 << r_va);
                n_strobe    = 1'b1;
                n_state     = S_IDLE;
            end

            S_DEG_LOAD: begin
                n_shift = row;
                n_acc   = '0;
                n_step  = '0;
                n_state = S_DEG_CNT;
            end

            S_DEG_CNT: begin
                n_acc   = r_acc + {3'b000, pop8(r_shift[7:0])};
                n_shift = r_shift >> 8;
                n_step  = r_step + 3'd1;
                if (r_step == 3'(DEG_STEPS - 1)) begin
                    n_strobe     = 1'b1;
                    n_out.degree = n_acc;
                    n_state      = S_IDLE;
                end
            end

            S_DFS_SCAN: begin
                if (cand != '0) begin
                    // A new vertex is found: the held one is known not to be last.
                    n_strobe        = 1'b1;
                    n_out.vertex_id = r_pend;
                    n_out.last      = 1'b0;
                    n_pend          = cand_idx;
                    n_visited       = r_visited | cand_low;
                    stk_wr_en       = 1'b1;
                    n_top           = cand_idx;
                    n_depth         = r_depth + 7'd1;
                    adj_rd_en       = 1'b1;
                    adj_rd_addr     = cand_idx;
                end else if (r_depth == 7'd1) begin
                    n_strobe        = 1'b1;
                    n_out.vertex_id = r_pend;
                    n_out.last      = 1'b1;
                    n_depth         = '0;
                    n_state         = S_IDLE;
                end else begin
                    stk_rd_en = 1'b1;
                    n_depth   = depth_m1;
                    n_state   = S_DFS_POP;
                end
            end

            S_DFS_POP: begin
                n_top       = r_stk_q;
                adj_rd_en   = 1'b1;
                adj_rd_addr = r_stk_q;
                n_state     = S_DFS_SCAN;
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_depth     <= '0;
            r_strobe    <= 1'b0;
            r_row_vld   <= '0;
            r_row_q_vld <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_depth  <= n_depth;
            r_strobe <= n_strobe;
            if (adj_wr_en) begin
                r_row_vld[adj_wr_addr] <= 1'b1;
            end
            if (adj_rd_en) begin
                r_row_q_vld <= r_row_vld[adj_rd_addr];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_va      <= n_va;
        r_vb      <= n_vb;
        r_visited <= n_visited;
        r_top     <= n_top;
        r_pend    <= n_pend;
        r_shift   <= n_shift;
        r_acc     <= n_acc;
        r_step    <= n_step;
        r_out     <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (adj_wr_en) begin
            r_adj[adj_wr_addr] <= adj_wr_data;
        end
        if (adj_rd_en) begin
            r_row_q <= r_adj[adj_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (stk_wr_en) begin
            r_stk[stk_wr_addr] <= r_top;
        end
        if (stk_rd_en) begin
            r_stk_q <= r_stk[stk_rd_addr];
        end
    end

    assign busy     = (r_state != S_IDLE);
    assign o_strobe = r_strobe;
    assign o_result = r_out;

`ifndef ASSERT_OFF
    a_idle_empty_stack: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (r_depth == '0))
        else $error("stack not empty while idle");

    a_top_visited: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DFS_SCAN) |-> r_visited[r_top])
        else $error("top of the walk is not marked visited");

    a_open_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_result.last) |-> (o_result.status == ST_OK))
        else $error("non-final result carries an error status");

    a_vertex_answer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_item.action == ACT_ADD_VERTEX) |=> (o_strobe && o_result.last))
        else $error("add vertex did not answer in the next cycle");
`endif

endmodule
